// ===== sv/etbt_pkg.sv =====
`timescale 1ns / 1ps
package etbt_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   localparam int TAG_W  = 64;
   localparam int TIME_W = 32;
   localparam int HOLD_W = 16;

   localparam logic OP_QUERY = 1'b0;
   localparam logic OP_BLOCK = 1'b1;

   typedef struct packed {
      logic [TAG_W-1:0]  key;
      logic [TIME_W-1:0] exp_first;
      logic [TIME_W-1:0] exp_second;
   } entry_type;

   typedef struct packed {
      logic shift;
   } cell_ctl_type;

endpackage

// ===== sv/etbt_if.sv =====
`timescale 1ns / 1ps
interface etbt_req_if
   import etbt_pkg::*;
;
   logic              valid;
   logic              ready;
   logic              opcode;
   logic [TAG_W-1:0]  tag_id;
   logic              reader_sel;
   logic [TIME_W-1:0] now_ms;
   logic [HOLD_W-1:0] hold_first_ms;
   logic [HOLD_W-1:0] hold_second_ms;

   modport source (output valid, opcode, tag_id, reader_sel, now_ms, hold_first_ms,
                   hold_second_ms, input ready);
   modport sink (input valid, opcode, tag_id, reader_sel, now_ms, hold_first_ms,
                 hold_second_ms, output ready);
endinterface

interface etbt_rsp_if;
   logic valid;
   logic ready;
   logic is_blocked;
   logic key_found;
   logic was_stored;

   modport source (output valid, is_blocked, key_found, was_stored, input ready);
   modport sink (input valid, is_blocked, key_found, was_stored, output ready);
endinterface

// ===== sv/etbt_cell.sv =====
`timescale 1ns / 1ps
module etbt_cell
   import etbt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  entry_type    entry_prev,
   output entry_type    entry_out
);

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = ctl.shift ? entry_prev : entry_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry_out = entry_ff;

endmodule

// ===== sv/etbt_scan.sv =====
`timescale 1ns / 1ps
module etbt_scan
   import etbt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   etbt_req_if.sink           req_chan,
   etbt_rsp_if.source         rsp_chan,
   input  entry_type          head,
   output entry_type          tail,
   output cell_ctl_type       ctl
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_WRITE,
      S_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  cnt_ff, cnt_in;
   logic              op_ff, op_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;
   logic              sel_ff, sel_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [HOLD_W-1:0] hold1_ff, hold1_in;
   logic [HOLD_W-1:0] hold2_ff, hold2_in;
   logic              match_hit_ff, match_hit_in;
   logic [IDX_W-1:0]  match_idx_ff, match_idx_in;
   logic              blocked_ff, blocked_in;
   logic              free_hit_ff, free_hit_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_blocked_ff, rsp_blocked_in;
   logic              rsp_found_ff, rsp_found_in;
   logic              rsp_stored_ff, rsp_stored_in;

   logic              key_eq;
   logic              slot_free;
   logic [TIME_W-1:0] sel_exp;
   logic [IDX_W-1:0]  target_idx;
   logic [TIME_W-1:0] sum_first;
   logic [TIME_W-1:0] sum_second;
   logic              last;

   always_comb begin
      key_eq     = (head.key == tag_ff);
      slot_free  = (head.exp_first <= now_ff) && (head.exp_second <= now_ff);
      sel_exp    = sel_ff ? head.exp_second : head.exp_first;
      target_idx = match_hit_ff ? match_idx_ff : free_idx_ff;
      sum_first  = now_ff + TIME_W'(hold1_ff);
      sum_second = now_ff + TIME_W'(hold2_ff);
      last       = (cnt_ff == LAST_IDX);
      ctl.shift  = (state_ff == S_SCAN) || (state_ff == S_WRITE);
   end

   // modify the entry on its way from head to tail
   always_comb begin
      tail = head;
      if (state_ff == S_WRITE && cnt_ff == target_idx) begin
         if (!match_hit_ff) begin
            tail.key = tag_ff;
         end
         if (hold1_ff != '0) begin
            tail.exp_first = sum_first;
         end else if (!match_hit_ff) begin
            tail.exp_first = '0;
         end
         if (hold2_ff != '0) begin
            tail.exp_second = sum_second;
         end else if (!match_hit_ff) begin
            tail.exp_second = '0;
         end
      end
   end

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      op_in          = op_ff;
      tag_in         = tag_ff;
      sel_in         = sel_ff;
      now_in         = now_ff;
      hold1_in       = hold1_ff;
      hold2_in       = hold2_ff;
      match_hit_in   = match_hit_ff;
      match_idx_in   = match_idx_ff;
      blocked_in     = blocked_ff;
      free_hit_in    = free_hit_ff;
      free_idx_in    = free_idx_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_blocked_in = rsp_blocked_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_stored_in  = rsp_stored_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               op_in        = req_chan.opcode;
               tag_in       = req_chan.tag_id;
               sel_in       = req_chan.reader_sel;
               now_in       = req_chan.now_ms;
               hold1_in     = req_chan.hold_first_ms;
               hold2_in     = req_chan.hold_second_ms;
               match_hit_in = 1'b0;
               free_hit_in  = 1'b0;
               blocked_in   = 1'b0;
               cnt_in       = '0;
               state_in     = S_SCAN;
            end
         end
         S_SCAN: begin
            if (!match_hit_ff && key_eq) begin
               match_hit_in = 1'b1;
               match_idx_in = cnt_ff;
               blocked_in   = (sel_exp > now_ff);
            end
            if (slot_free) begin
               free_hit_in = 1'b1;
               free_idx_in = cnt_ff;
            end
            cnt_in = last ? '0 : cnt_ff + 1'b1;
            if (last) begin
               if (op_ff == OP_BLOCK && (match_hit_in || free_hit_in)) begin
                  state_in = S_WRITE;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_WRITE: begin
            cnt_in = last ? '0 : cnt_ff + 1'b1;
            if (last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_found_in   = match_hit_ff;
               rsp_blocked_in = (op_ff == OP_QUERY) && blocked_ff;
               rsp_stored_in  = (op_ff == OP_BLOCK) && (match_hit_ff || free_hit_ff);
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         match_hit_ff <= 1'b0;
         free_hit_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         match_hit_ff <= match_hit_in;
         free_hit_ff  <= free_hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff          <= op_in;
      tag_ff         <= tag_in;
      sel_ff         <= sel_in;
      now_ff         <= now_in;
      hold1_ff       <= hold1_in;
      hold2_ff       <= hold2_in;
      match_idx_ff   <= match_idx_in;
      blocked_ff     <= blocked_in;
      free_idx_ff    <= free_idx_in;
      rsp_blocked_ff <= rsp_blocked_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_stored_ff  <= rsp_stored_in;
   end

   assign req_chan.ready      = (state_ff == S_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.is_blocked = rsp_blocked_ff;
   assign rsp_chan.key_found  = rsp_found_ff;
   assign rsp_chan.was_stored = rsp_stored_ff;

endmodule

// ===== sv/expiring_tag_block_table.sv =====
`timescale 1ns / 1ps
// A query or an unstored block request makes one pass of the cell row before the response
// is valid; a block request that writes makes a second pass to write its entry.
// A new request is taken only in idle, once the response of the last one has been issued; the
// cell row rotates past the single compare point, one entry per cycle.
// Reset: synchronous; clears every entry to zero, response channel empty.
module expiring_tag_block_table
   import etbt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   etbt_req_if.sink   req_chan,
   etbt_rsp_if.source rsp_chan
);

   entry_type    cell_q [TABLE_ENTRIES];
   entry_type    tail;
   cell_ctl_type ctl;

   etbt_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .head     (cell_q[0]),
      .tail     (tail),
      .ctl      (ctl)
   );

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      entry_type prev;
      if (i == TABLE_ENTRIES - 1) begin : g_last
         assign prev = tail;
      end else begin : g_mid
         assign prev = cell_q[i+1];
      end
      etbt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .entry_prev (prev),
         .entry_out  (cell_q[i])
      );
   end

endmodule

// ===== sv/etbt_checker.sv =====
`timescale 1ns / 1ps
module etbt_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_is_blocked,
   input logic rsp_key_found,
   input logic rsp_was_stored
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_is_blocked, rsp_key_found,
                                                        rsp_was_stored}))
      else $error("response dropped or changed while stalled");

   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_is_blocked && rsp_was_stored))
      else $error("response both blocked and stored");

   a_blocked_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_blocked |-> rsp_key_found)
      else $error("blocked without a matching tag");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while busy");

endmodule

bind expiring_tag_block_table etbt_checker u_etbt_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_is_blocked (rsp_chan.is_blocked),
   .rsp_key_found  (rsp_chan.key_found),
   .rsp_was_stored (rsp_chan.was_stored)
);
